FILE: sv/cwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwa_pkg
// Shared types, register codes and constants of the capture window averager.
// ----------------------------------------------------------------------------
package cwa_pkg;

    localparam int CHANNEL_COUNT_DEF = 8;

    // input actions
    localparam logic [1:0] ACT_POLL    = 2'd0;
    localparam logic [1:0] ACT_CAPTURE = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_WINDOW_LEN    = 3'd0;
    localparam logic [2:0] REG_SETTLE_SKIP   = 3'd1;
    localparam logic [2:0] REG_RANGE_LOW     = 3'd2;
    localparam logic [2:0] REG_RANGE_HIGH    = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_POLLS = 3'd4;
    localparam logic [2:0] REG_NEAR_BAND     = 3'd5;
    localparam logic [2:0] REG_CHANNEL       = 3'd6;

    // reset values of the registers
    localparam logic [7:0]  WINDOW_LEN_RST    = 8'd37;
    localparam logic [7:0]  SETTLE_SKIP_RST   = 8'd7;
    localparam logic [15:0] RANGE_LOW_RST     = 16'h7500;
    localparam logic [15:0] RANGE_HIGH_RST    = 16'hBF00;
    localparam logic [7:0]  TIMEOUT_POLLS_RST = 8'd20;
    localparam logic [15:0] NEAR_BAND_RST     = 16'd15;
    localparam logic [3:0]  CHANNEL_RST       = 4'd1;

    localparam logic [15:0] SUM_CEILING = 16'hFF00;

    // x / 5 for x below 2^19 as (x * DIV5_MULT) >> DIV5_SHIFT
    localparam int          DIV5_SHIFT = 21;
    localparam logic [18:0] DIV5_MULT  = 19'd419431;

    typedef struct packed {
        logic [7:0]  window_len;
        logic [7:0]  settle_skip;
        logic [15:0] range_low;
        logic [15:0] range_high;
        logic [7:0]  timeout_polls;
        logic [15:0] near_band;
        logic [3:0]  channel;
    } cfg_t;

    typedef struct packed {
        logic        armed;
        logic [8:0]  count;
        logic [7:0]  rem;      // count modulo the window length
        logic [15:0] sum;
        logic [7:0]  idle;
        logic [15:0] samp0;
        logic [15:0] samp1;
    } state_t;

    typedef struct packed {
        logic        done_res;
        logic        timed_out;
        logic        overflow;
        logic        sample_written;
        logic        sample_slot;
        logic [15:0] sample_value;
        logic        negative_drive;
    } result_t;

    function automatic logic [7:0] eff_len(input logic [7:0] len);
        eff_len = (len == 8'd0) ? 8'd1 : len;
    endfunction

endpackage

FILE: sv/cwa_rem_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwa_rem_unit
// Bit-serial remainder of the capture count by the window length.
// ----------------------------------------------------------------------------
module cwa_rem_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [8:0] dividend,
    input  logic [7:0] divisor,
    output logic       busy,
    output logic       done,
    output logic [7:0] rem
);

    localparam int STEPS = 9;
    localparam logic [3:0] LAST_STEP = 4'(STEPS - 1);

    logic       run_reg;
    logic       done_reg;
    logic [3:0] step_reg;
    logic [8:0] quot_reg;
    logic [7:0] r_reg;
    logic [8:0] trial;
    logic [7:0] r_next;

    // shift in one dividend bit, subtract when it fits
    assign trial  = {r_reg, quot_reg[8]};
    assign r_next = (trial >= {1'b0, divisor}) ? 8'(trial - {1'b0, divisor}) : trial[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg + 4'd1;
            if (step_reg == LAST_STEP)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            r_reg    <= '0;
        end
        else if (run_reg)
        begin
            quot_reg <= {quot_reg[7:0], 1'b0};
            r_reg    <= r_next;
        end
    end

    assign busy = run_reg | done_reg;
    assign done = done_reg;
    assign rem  = r_reg;

endmodule

FILE: sv/cwa_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwa_step
// Next-state and result logic for one accepted item.
// ----------------------------------------------------------------------------
module cwa_step
#(
    parameter int CHANNEL_COUNT = cwa_pkg::CHANNEL_COUNT_DEF
)
(
    input  logic                     take,
    input  logic [1:0]               action,
    input  logic [15:0]              capture_value,
    input  cwa_pkg::cfg_t            cfg,
    input  cwa_pkg::state_t          st,
    input  logic [CHANNEL_COUNT-1:0] flags,
    output cwa_pkg::state_t          st_next,
    output logic [CHANNEL_COUNT-1:0] flags_next,
    output cwa_pkg::result_t         res
);

    logic [CHANNEL_COUNT-1:0] sel;
    logic [7:0]  w;
    logic [8:0]  w2;
    logic [16:0] sum_wide;
    logic [15:0] sum_add;
    logic [15:0] sum1;
    logic [8:0]  cnt_inc;
    logic        end2;
    logic [8:0]  cnt1;
    logic [8:0]  rem_inc;
    logic [7:0]  rem1;
    logic        win_end;
    logic        slot_k;
    logic        bad;
    logic [15:0] old;
    logic [15:0] diff;
    logic [18:0] blend_num;
    logic [37:0] prod;
    logic [15:0] new_samp;
    logic [7:0]  idle1;

    // one-hot channel select, all zero when the channel is out of range
    always_comb
    begin
        for (int i = 0; i < CHANNEL_COUNT; i++)
            sel[i] = ({1'b0, cfg.channel} == 5'(i + 1));
    end

    assign w        = cwa_pkg::eff_len(cfg.window_len);
    assign w2       = {w, 1'b0};
    assign sum_wide = {1'b0, st.sum} + {1'b0, capture_value};
    assign sum_add  = (sum_wide >= {1'b0, cwa_pkg::SUM_CEILING}) ? cwa_pkg::SUM_CEILING
                                                                 : sum_wide[15:0];
    assign sum1     = (st.rem >= cfg.settle_skip) ? sum_add : st.sum;
    assign cnt_inc  = st.count + 9'd1;
    assign end2     = (cnt_inc >= w2);
    assign cnt1     = end2 ? 9'd0 : cnt_inc;
    assign rem_inc  = {1'b0, st.rem} + 9'd1;
    assign rem1     = ((cnt1 == 9'd0) || (rem_inc == {1'b0, w})) ? 8'd0 : rem_inc[7:0];
    assign win_end  = (rem1 == 8'd0);
    assign slot_k   = (cnt1 == 9'd0);
    assign bad      = (sum1 > cfg.range_high) || (sum1 < cfg.range_low);
    assign old      = slot_k ? st.samp1 : st.samp0;
    assign diff     = (old >= sum1) ? (old - sum1) : (sum1 - old);
    assign blend_num = {1'b0, old, 2'b00} + {3'b000, sum1};
    assign prod     = {19'd0, blend_num} * {19'd0, cwa_pkg::DIV5_MULT};
    assign new_samp = (diff <= cfg.near_band) ? prod[cwa_pkg::DIV5_SHIFT +: 16] : sum1;
    assign idle1    = st.idle + 8'd1;

    always_comb
    begin
        st_next    = st;
        flags_next = flags;
        res        = '0;
        if (take)
        begin
            case (action)
                cwa_pkg::ACT_RESTART:
                begin
                    st_next.armed = 1'b1;
                end
                cwa_pkg::ACT_CAPTURE:
                begin
                    if (st.armed)
                    begin
                        st_next.sum   = sum1;
                        st_next.count = cnt1;
                        st_next.rem   = rem1;
                        if (end2)
                        begin
                            res.done_res  = 1'b1;
                            st_next.armed = 1'b0;
                        end
                        if (win_end)
                        begin
                            st_next.idle = '0;
                            if (slot_k)
                            begin
                                if (bad)
                                    flags_next = flags | sel;
                            end
                            else
                            begin
                                res.negative_drive = 1'b1;
                                flags_next = bad ? (flags | sel) : (flags & ~sel);
                            end
                            if (|(flags_next & sel))
                            begin
                                res.done_res  = 1'b1;
                                st_next.armed = 1'b0;
                                st_next.count = '0;
                                st_next.rem   = '0;
                            end
                            else
                            begin
                                if (slot_k)
                                    st_next.samp1 = new_samp;
                                else
                                    st_next.samp0 = new_samp;
                                res.sample_written = 1'b1;
                                res.sample_slot    = slot_k;
                                res.sample_value   = new_samp;
                            end
                            st_next.sum = '0;
                        end
                    end
                end
                cwa_pkg::ACT_POLL:
                begin
                    if (st.armed)
                    begin
                        st_next.idle = idle1;
                        if (idle1 == cfg.timeout_polls)
                        begin
                            flags_next    = flags | sel;
                            res.done_res  = 1'b1;
                            res.timed_out = 1'b1;
                            st_next.armed = 1'b0;
                            st_next.idle  = '0;
                            st_next.count = '0;
                            st_next.rem   = '0;
                            st_next.sum   = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        res.overflow = |(flags_next & sel);
    end

endmodule

FILE: sv/cwa_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwa_obuf
// Two-entry result buffer between the update logic and the output channel.
// ----------------------------------------------------------------------------
module cwa_obuf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cwa_pkg::result_t din,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output cwa_pkg::result_t dout
);

    cwa_pkg::result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       pop;

    assign pop       = out_valid & out_ready;
    assign ready     = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign dout      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

FILE: sv/capture_window_averager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_window_averager_core
// Averages timer captures over two windows per run and keeps two samples.
// ----------------------------------------------------------------------------
// input channel s_*: one item per handshake, tuser carries the action (poll,
// capture, restart) and tdata the captured count. output channel m_*: one
// result item per input item, tlast marks the item that ended a run.
// cfg_*: register writes by index; cfg_ready is always high.
// throughput: one item per cycle while s_tready is high; the update of
// counters, window sum, flags and stored samples is a single registered
// step. the result is written into a two-entry buffer at the accepting edge
// and shows on m_* in the cycle after. if the receiver stalls, one more
// item is accepted, then s_tready drops until the receiver takes a result
// item. a write of window_len rebuilds the window position with a bit-serial
// remainder unit: s_tready stays low until the remainder is written back.
// reset: registers take their default values, counters, sum, samples and
// overflow flags clear, the run is armed and the buffer empties.
// ----------------------------------------------------------------------------
module capture_window_averager_core
#(
    parameter int CHANNEL_COUNT = cwa_pkg::CHANNEL_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] capture_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] timed_out, [1] overflow, [17:2] sample_value,
                                   // [18] negative_drive, [23:19] zero
    output logic [1:0]  m_tuser,   // [0] sample_written, [1] sample_slot
    output logic        m_tlast,   // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    cwa_pkg::cfg_t            cfg_reg;
    cwa_pkg::state_t          st_reg;
    cwa_pkg::state_t          st_next;
    logic [CHANNEL_COUNT-1:0] flags_reg;
    logic [CHANNEL_COUNT-1:0] flags_next;
    cwa_pkg::result_t         step_res;
    cwa_pkg::result_t         out_res;
    logic                     accept;
    logic                     cfg_write;
    logic                     len_write;
    logic                     rem_busy;
    logic                     rem_done;
    logic [7:0]               rem_val;
    logic                     buf_ready;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid & cfg_ready;
    assign len_write = cfg_write && (cfg_addr == cwa_pkg::REG_WINDOW_LEN);
    assign s_tready  = buf_ready & ~rem_busy;
    assign accept    = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_len    <= cwa_pkg::WINDOW_LEN_RST;
            cfg_reg.settle_skip   <= cwa_pkg::SETTLE_SKIP_RST;
            cfg_reg.range_low     <= cwa_pkg::RANGE_LOW_RST;
            cfg_reg.range_high    <= cwa_pkg::RANGE_HIGH_RST;
            cfg_reg.timeout_polls <= cwa_pkg::TIMEOUT_POLLS_RST;
            cfg_reg.near_band     <= cwa_pkg::NEAR_BAND_RST;
            cfg_reg.channel       <= cwa_pkg::CHANNEL_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_addr)
                cwa_pkg::REG_WINDOW_LEN:    cfg_reg.window_len    <= cfg_data[7:0];
                cwa_pkg::REG_SETTLE_SKIP:   cfg_reg.settle_skip   <= cfg_data[7:0];
                cwa_pkg::REG_RANGE_LOW:     cfg_reg.range_low     <= cfg_data;
                cwa_pkg::REG_RANGE_HIGH:    cfg_reg.range_high    <= cfg_data;
                cwa_pkg::REG_TIMEOUT_POLLS: cfg_reg.timeout_polls <= cfg_data[7:0];
                cwa_pkg::REG_NEAR_BAND:     cfg_reg.near_band     <= cfg_data;
                cwa_pkg::REG_CHANNEL:       cfg_reg.channel       <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    cwa_rem_unit u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (len_write),
        .dividend (st_reg.count),
        .divisor  (cwa_pkg::eff_len(cfg_reg.window_len)),
        .busy     (rem_busy),
        .done     (rem_done),
        .rem      (rem_val)
    );

    cwa_step #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_step
    (
        .take          (accept),
        .action        (s_tuser),
        .capture_value (s_tdata),
        .cfg           (cfg_reg),
        .st            (st_reg),
        .flags         (flags_reg),
        .st_next       (st_next),
        .flags_next    (flags_next),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.armed <= 1'b1;
            st_reg.count <= '0;
            st_reg.rem   <= '0;
            st_reg.sum   <= '0;
            st_reg.idle  <= '0;
            st_reg.samp0 <= '0;
            st_reg.samp1 <= '0;
            flags_reg    <= '0;
        end
        else if (accept)
        begin
            st_reg    <= st_next;
            flags_reg <= flags_next;
        end
        else if (rem_done)
        begin
            st_reg.rem <= rem_val;
        end
    end

    cwa_obuf u_obuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (step_res),
        .ready     (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (out_res)
    );

    assign m_tlast = out_res.done_res;
    assign m_tuser = {out_res.sample_slot, out_res.sample_written};
    assign m_tdata = {5'd0, out_res.negative_drive, out_res.sample_value,
                      out_res.overflow, out_res.timed_out};

    // window position stays below the window length once rebuilt
    a_rem_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        !rem_busy |-> (st_reg.rem < cwa_pkg::eff_len(cfg_reg.window_len)))
        else $error("window position out of range");

    a_no_take_while_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
        rem_busy |-> !s_tready)
        else $error("item taken while window position is rebuilt");

    // a disarmed run ignores polls and captures
    a_disarmed_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !st_reg.armed && (s_tuser != cwa_pkg::ACT_RESTART))
        |=> ($stable(st_reg) && $stable(flags_reg)))
        else $error("state changed while disarmed");

    a_done_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_res.done_res) |=> !st_reg.armed)
        else $error("run end left the block armed");

endmodule

FILE: sim/tb_capture_window_averager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_capture_window_averager_core
// Self-checking bench for the capture window averager core.
// ----------------------------------------------------------------------------
// polls, captures and restarts are queued per phase and sent by a clocked
// driver with random gaps. every accepted item is run through a local model
// of the window logic, and the predicted result is compared field by field
// with the next result item from the core. registers change only between
// phases, once the output side is empty. phases cover the register limits,
// a zero window length, channels outside the flag array and random settings.
// ----------------------------------------------------------------------------
module tb_capture_window_averager_core;

    localparam int         NCHAN      = cwa_pkg::CHANNEL_COUNT_DEF;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] capture_value;
    } capture_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_data = '0;

    capture_window_averager_core #(.CHANNEL_COUNT(NCHAN)) u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // model copy of registers and run state
    cwa_pkg::cfg_t shadow_cfg;
    int unsigned   run_count;
    int unsigned   run_sum;
    int unsigned   poll_count;
    logic [15:0]   kept_samples [2];
    logic          chan_flags [NCHAN];
    logic          run_armed;

    capture_item_t    pending_items [$];
    cwa_pkg::result_t expected_results [$];
    capture_item_t    next_item;
    cwa_pkg::result_t predicted;
    cwa_pkg::result_t seen_res;
    cwa_pkg::result_t want_res;

    int src_idle_max = 4;
    int snk_idle_max = 4;
    int src_wait = 0;
    int snk_wait = 0;
    int sink_hold_req = 0;
    int snk_hold_left = 0;

    int errors = 0;
    int items_in = 0;
    int results_seen = 0;
    int runs_ended = 0;
    int timeouts_seen = 0;
    int samples_written = 0;
    int first_closes = 0;
    int phases_run = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("run did not finish in time, %0d results still pending",
                 expected_results.size());
        $display("tb_capture_window_averager_core: done, errors");
        $finish;
    end

    function automatic logic flag_read();
        if (shadow_cfg.channel >= 1 && shadow_cfg.channel <= NCHAN)
            return chan_flags[shadow_cfg.channel - 1];
        return 1'b0;
    endfunction

    function automatic void flag_write(input logic v);
        if (shadow_cfg.channel >= 1 && shadow_cfg.channel <= NCHAN)
            chan_flags[shadow_cfg.channel - 1] = v;
    endfunction

    function automatic void load_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            cwa_pkg::REG_WINDOW_LEN:    shadow_cfg.window_len    = data[7:0];
            cwa_pkg::REG_SETTLE_SKIP:   shadow_cfg.settle_skip   = data[7:0];
            cwa_pkg::REG_RANGE_LOW:     shadow_cfg.range_low     = data;
            cwa_pkg::REG_RANGE_HIGH:    shadow_cfg.range_high    = data;
            cwa_pkg::REG_TIMEOUT_POLLS: shadow_cfg.timeout_polls = data[7:0];
            cwa_pkg::REG_NEAR_BAND:     shadow_cfg.near_band     = data;
            cwa_pkg::REG_CHANNEL:       shadow_cfg.channel       = data[3:0];
            default: ;
        endcase
    endfunction

    // advance the window state by one item and work out its result
    function automatic cwa_pkg::result_t step_averager(input logic [1:0] act,
                                                       input logic [15:0] cap);
        cwa_pkg::result_t r;
        int unsigned      w;
        int unsigned      total;
        int unsigned      slot;
        int unsigned      prev;
        int unsigned      gap;
        int unsigned      blended;
        logic             bad;
        r = '0;
        w = (shadow_cfg.window_len == 0) ? 1 : shadow_cfg.window_len;
        if (act == cwa_pkg::ACT_RESTART)
            run_armed = 1'b1;
        else if (run_armed && act == cwa_pkg::ACT_CAPTURE)
        begin
            if ((run_count % w) >= shadow_cfg.settle_skip)
            begin
                total = run_sum + cap;
                run_sum = (total >= cwa_pkg::SUM_CEILING) ? cwa_pkg::SUM_CEILING : total;
            end
            run_count = (run_count + 1) & 'h1FF;
            if (run_count >= 2 * w)
            begin
                run_count = 0;
                r.done_res = 1'b1;
                run_armed = 1'b0;
            end
            if ((run_count % w) == 0)
            begin
                bad = (run_sum > shadow_cfg.range_high) || (run_sum < shadow_cfg.range_low);
                poll_count = 0;
                if (run_count == 0)
                begin
                    // second window can only raise the flag
                    slot = 1;
                    if (bad)
                        flag_write(1'b1);
                end
                else
                begin
                    slot = 0;
                    r.negative_drive = 1'b1;
                    flag_write(bad);
                end
                if (flag_read())
                begin
                    r.done_res = 1'b1;
                    run_armed = 1'b0;
                    poll_count = 0;
                    run_count = 0;
                end
                else
                begin
                    prev = kept_samples[slot];
                    gap = (prev >= run_sum) ? prev - run_sum : run_sum - prev;
                    blended = (gap <= shadow_cfg.near_band) ? (4 * prev + run_sum) / 5
                                                            : run_sum;
                    kept_samples[slot] = blended[15:0];
                    r.sample_written = 1'b1;
                    r.sample_slot = slot[0];
                    r.sample_value = blended[15:0];
                end
                run_sum = 0;
            end
        end
        else if (run_armed && act == cwa_pkg::ACT_POLL)
        begin
            poll_count = (poll_count + 1) & 'hFF;
            if (poll_count == shadow_cfg.timeout_polls)
            begin
                flag_write(1'b1);
                r.done_res = 1'b1;
                r.timed_out = 1'b1;
                run_armed = 1'b0;
                poll_count = 0;
                run_count = 0;
                run_sum = 0;
            end
        end
        r.overflow = flag_read();
        return r;
    endfunction

    // sender side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            src_wait = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = step_averager(s_tuser, s_tdata);
                expected_results.push_back(predicted);
                items_in++;
                runs_ended += predicted.done_res;
                timeouts_seen += predicted.timed_out;
                samples_written += predicted.sample_written;
                first_closes += predicted.negative_drive;
            end
            if (s_tvalid && !s_tready)
                ;   // hold the item until taken
            else if (src_wait > 0)
            begin
                src_wait--;
                s_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                next_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= next_item.action;
                s_tdata <= next_item.capture_value;
                src_wait = $urandom_range(0, src_idle_max);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver side and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_wait = 0;
            snk_hold_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen_res.done_res       = m_tlast;
                seen_res.timed_out      = m_tdata[0];
                seen_res.overflow       = m_tdata[1];
                seen_res.sample_value   = m_tdata[17:2];
                seen_res.negative_drive = m_tdata[18];
                seen_res.sample_written = m_tuser[0];
                seen_res.sample_slot    = m_tuser[1];
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result item with nothing pending", $realtime);
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    results_seen++;
                    if (seen_res !== want_res)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%0t: result %0d mismatch", $realtime, results_seen);
                            $display("  exp d=%0b t=%0b o=%0b w=%0b s=%0b v=%04h n=%0b",
                                     want_res.done_res, want_res.timed_out,
                                     want_res.overflow, want_res.sample_written,
                                     want_res.sample_slot, want_res.sample_value,
                                     want_res.negative_drive);
                            $display("  got d=%0b t=%0b o=%0b w=%0b s=%0b v=%04h n=%0b",
                                     seen_res.done_res, seen_res.timed_out,
                                     seen_res.overflow, seen_res.sample_written,
                                     seen_res.sample_slot, seen_res.sample_value,
                                     seen_res.negative_drive);
                        end
                    end
                end
                snk_wait = $urandom_range(0, snk_idle_max);
            end
            if (sink_hold_req > 0)
            begin
                snk_hold_left = sink_hold_req;
                sink_hold_req = 0;
            end
            if (snk_hold_left > 0)
            begin
                snk_hold_left--;
                m_tready <= 1'b0;
            end
            else if (snk_wait > 0)
            begin
                snk_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic push_item(input logic [1:0] act, input logic [15:0] cap);
        capture_item_t it;
        it.action = act;
        it.capture_value = cap;
        pending_items.push_back(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        load_reg(idx, data);
    endtask

    task automatic configure(input int w, input int skip, input int lo, input int hi,
                             input int polls, input int band, input int ch);
        write_reg(cwa_pkg::REG_WINDOW_LEN, 16'(w));
        write_reg(cwa_pkg::REG_SETTLE_SKIP, 16'(skip));
        write_reg(cwa_pkg::REG_RANGE_LOW, 16'(lo));
        write_reg(cwa_pkg::REG_RANGE_HIGH, 16'(hi));
        write_reg(cwa_pkg::REG_TIMEOUT_POLLS, 16'(polls));
        write_reg(cwa_pkg::REG_NEAR_BAND, 16'(band));
        write_reg(cwa_pkg::REG_CHANNEL, 16'(ch));
        cfg_valid <= 1'b0;
    endtask

    // sender idles until every result of the phase is back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        phases_run++;
    endtask

    function automatic logic [15:0] draw_capture(input int base);
        int v;
        case ($urandom_range(0, 19))
            0:       v = 0;
            1:       v = 'hFFFF;
            2, 3:    v = $urandom_range(0, 'hFFFF);
            default: v = base + $urandom_range(0, base / 4 + 1) - base / 8;
        endcase
        if (v < 0)
            v = 0;
        if (v > 'hFFFF)
            v = 'hFFFF;
        return v[15:0];
    endfunction

    task automatic run_phase(input int n, input int base, input int src_max,
                             input int snk_max, input int hold);
        int r;
        src_idle_max = src_max;
        snk_idle_max = snk_max;
        if (hold > 0)
        begin
            @(negedge clk);
            sink_hold_req = hold;
        end
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
                push_item(cwa_pkg::ACT_CAPTURE, draw_capture(base));
            else if (r < 86)
                push_item(cwa_pkg::ACT_POLL, 16'($urandom_range(0, 'hFFFF)));
            else if (r < 97)
                push_item(cwa_pkg::ACT_RESTART, 16'($urandom_range(0, 'hFFFF)));
            else
                push_item(ACT_UNUSED, 16'($urandom_range(0, 'hFFFF)));
        end
        wait_drained();
    endtask

    // random settings sized so window sums land both inside and outside the range
    task automatic random_phase(input int n, input int src_max, input int snk_max,
                                input int hold);
        int w;
        int skip;
        int span;
        int base;
        int est;
        int hi;
        int band;
        int polls;
        w = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(8, 12);
        skip = ($urandom_range(0, 7) == 0) ? $urandom_range(w, 254) : $urandom_range(0, w - 1);
        span = (skip < w) ? w - skip : 0;
        base = $urandom_range(0, 'h1FFF);
        est = span * base;
        if (est > 'hFF00)
            est = 'hFF00;
        hi = est + est / 8;
        if (hi > 'hFFFF)
            hi = 'hFFFF;
        case ($urandom_range(0, 3))
            0:       band = 0;
            1:       band = 15;
            2:       band = est / 16;
            default: band = 'hFFFF;
        endcase
        polls = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(2, 8);
        configure(w, skip, est - est / 8, hi, polls, band, $urandom_range(1, NCHAN));
        run_phase(n, base, src_max, snk_max, hold);
    endtask

    initial
    begin
        shadow_cfg.window_len    = cwa_pkg::WINDOW_LEN_RST;
        shadow_cfg.settle_skip   = cwa_pkg::SETTLE_SKIP_RST;
        shadow_cfg.range_low     = cwa_pkg::RANGE_LOW_RST;
        shadow_cfg.range_high    = cwa_pkg::RANGE_HIGH_RST;
        shadow_cfg.timeout_polls = cwa_pkg::TIMEOUT_POLLS_RST;
        shadow_cfg.near_band     = cwa_pkg::NEAR_BAND_RST;
        shadow_cfg.channel       = cwa_pkg::CHANNEL_RST;
        run_count = 0;
        run_sum = 0;
        poll_count = 0;
        kept_samples[0] = '0;
        kept_samples[1] = '0;
        foreach (chan_flags[i])
            chan_flags[i] = 1'b0;
        run_armed = 1'b1;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // default registers: restart while armed, unused action, field extremes
        push_item(cwa_pkg::ACT_RESTART, 16'h0000);
        push_item(ACT_UNUSED, 16'hFFFF);
        push_item(cwa_pkg::ACT_POLL, 16'hA5A5);
        push_item(cwa_pkg::ACT_CAPTURE, 16'h0000);
        push_item(cwa_pkg::ACT_CAPTURE, 16'hFFFF);
        wait_drained();

        // short window, window length changed mid-run, poll timeout
        configure(8, 0, 0, 'hFFFF, 3, 'hFFFF, 8);
        push_item(cwa_pkg::ACT_POLL, 16'h5A5A);
        push_item(cwa_pkg::ACT_POLL, 16'h0000);
        push_item(cwa_pkg::ACT_CAPTURE, 16'hFFFF);   // ignored, run over
        push_item(cwa_pkg::ACT_POLL, 16'hFFFF);      // ignored, run over
        push_item(cwa_pkg::ACT_RESTART, 16'h1234);
        // first window saturates, second one ends the run
        repeat (8) push_item(cwa_pkg::ACT_CAPTURE, 16'hFFFF);
        repeat (8) push_item(cwa_pkg::ACT_CAPTURE, 16'h1000);
        wait_drained();

        // register limits
        configure(255, 254, 0, 0, 255, 0, 1);
        run_phase(40, $urandom_range(0, 'hFFFF), 4, 4, 0);
        configure(8, 0, 0, 'hFFFF, 1, 0, NCHAN);
        run_phase(40, 'h2000, 4, 4, 0);
        // zero window length acts as one, flag writes dropped
        configure(0, 0, 'h100, 'hFFFF, 4, 'hFFFF, 0);
        run_phase(25, 'h800, 4, 4, 0);
        configure(1, 254, 'h100, 'hFFFF, 6, 15, 12);
        run_phase(20, 'h800, 4, 4, 0);

        random_phase(75, 4, 4, 0);
        random_phase(75, 4, 4, 0);
        // long receiver stall while the sender keeps offering
        random_phase(75, 0, 4, 60);
        random_phase(75, 0, 0, 0);
        random_phase(75, 4, 4, 0);
        random_phase(75, 2, 4, 0);

        repeat (4) @(posedge clk);
        $display("covered %0d items in %0d phases: %0d runs ended, %0d by idle timeout",
                 items_in, phases_run, runs_ended, timeouts_seen);
        $display("%0d first-window closes, %0d sample updates, %0d results checked, %0d errors",
                 first_closes, samples_written, results_seen, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb_capture_window_averager_core: done, clean");
        else
            $display("tb_capture_window_averager_core: done, errors");
        $finish;
    end

endmodule
